// ===== rtl/core/ssq_pkg.sv =====
// ----------------------------------------------------------------------------
// ssq_pkg: shared types and constants of the stepped shot sequencer
// Register indexes, the sequencer state record, the latched configuration
// and the result record carried from the step logic to the output stage.
// ----------------------------------------------------------------------------
package ssq_pkg;

  // Shutter pulse length in ticks, counted from the start of the hold
  localparam logic [15:0] PULSE_TICKS = 16'd160;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHOT_TOTAL   = 3'd0,
    REG_MOVE_DIST    = 3'd1,
    REG_START_DELAY  = 3'd2,
    REG_SETTLE_TIME  = 3'd3,
    REG_HOLD_TIME    = 3'd4,
    REG_RETURN_HOME  = 3'd5
  } cfg_reg_t;

  // Programmed configuration
  typedef struct packed {
    logic [15:0]        shot_total;
    logic signed [15:0] move_distance;
    logic [15:0]        start_delay;
    logic [15:0]        settle_time;
    logic [15:0]        hold_time;
    logic               return_home_enable;
  } cfg_t;

  // Sequencer state, including the copies taken at arm time
  typedef struct packed {
    logic [15:0]        delay_left;
    logic [15:0]        shots_remaining;
    logic [15:0]        settle_left;
    logic [15:0]        hold_left;
    logic               first_shot_pending;
    logic               return_pending;
    logic               shutter_level;
    logic signed [15:0] lat_steps;
    logic [15:0]        lat_settle;
    logic [15:0]        lat_hold;
  } seq_state_t;

  // One result
  typedef struct packed {
    logic               shutter_on;
    logic               move_request;
    logic signed [15:0] move_steps;
    logic               home_request;
    logic               zero_position;
    logic [15:0]        shots_left;
  } result_t;

endpackage

// ===== rtl/core/ssq_step.sv =====
// ----------------------------------------------------------------------------
// ssq_step: next-state and result logic for one request
// Applies an arm or a tick to the current sequencer state and forms the
// result of that request. Purely combinational.
// ----------------------------------------------------------------------------
module ssq_step (
  input  ssq_pkg::cfg_t       cfg,
  input  ssq_pkg::seq_state_t cur,
  input  logic                kind,
  input  logic                motor_idle,
  output ssq_pkg::seq_state_t nxt,
  output ssq_pkg::result_t    res
);

  logic [15:0] hold_dec;

  assign hold_dec = cur.hold_left - 16'd1;

  // Pick the single action for this request
  always_comb begin
    nxt               = cur;
    res               = '0;
    if (kind) begin
      // Arm: latch the configuration and restart the sequence
      nxt.shots_remaining    = cfg.shot_total;
      nxt.lat_steps          = cfg.move_distance;
      nxt.delay_left         = cfg.start_delay;
      nxt.lat_settle         = cfg.settle_time;
      nxt.lat_hold           = cfg.hold_time;
      nxt.return_pending     = cfg.return_home_enable;
      nxt.hold_left          = '0;
      nxt.settle_left        = '0;
      nxt.first_shot_pending = 1'b1;
      res.zero_position      = 1'b1;
    end else if (cur.delay_left != '0) begin
      nxt.delay_left = cur.delay_left - 16'd1;
    end else if (motor_idle) begin
      if (cur.shots_remaining != '0 && cur.hold_left == '0) begin
        // Start a shot; the first one needs no move
        nxt.shots_remaining = cur.shots_remaining - 16'd1;
        if (!cur.first_shot_pending) begin
          res.move_request = 1'b1;
          res.move_steps   = cur.lat_steps;
        end
        nxt.first_shot_pending = 1'b0;
        nxt.hold_left          = cur.lat_hold;
        nxt.settle_left        = cur.lat_settle;
      end else if (cur.settle_left != '0) begin
        // Count settle down, fire the shutter on reaching zero
        nxt.settle_left = cur.settle_left - 16'd1;
        if (cur.settle_left == 16'd1) begin
          nxt.shutter_level = 1'b1;
        end
      end else if (cur.hold_left != '0) begin
        // Count hold down, drop the shutter once the pulse has run out
        nxt.hold_left = hold_dec;
        if (cur.lat_hold >= ssq_pkg::PULSE_TICKS &&
            hold_dec == cur.lat_hold - ssq_pkg::PULSE_TICKS) begin
          nxt.shutter_level = 1'b0;
        end
      end else if (cur.shots_remaining == '0 && cur.return_pending) begin
        nxt.return_pending = 1'b0;
        res.home_request   = 1'b1;
      end
    end
    res.shutter_on = nxt.shutter_level;
    res.shots_left = nxt.shots_remaining;
  end

endmodule

// ===== rtl/core/stepped_shot_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// stepped_shot_sequencer_core: timed shot sequencer with stepper moves
// Takes arm and tick requests and produces one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): in_kind 1 = arm, 0 = one tick, with
//   in_motor_idle sampled alongside. Every accepted request yields exactly
//   one result on the output channel (out_valid/out_ready), in order.
//   Configuration: write cfg_wdata to register cfg_index while cfg_we is
//   high; only do so while the block is idle. Shots use values copied at arm.
//   A result goes to the result register, or to the skid entry if the output
//   stalls. Throughput: one request per cycle while in_ready is high, set by
//   the combinational step logic between the state and result registers.
//   Stall: a result register plus a one-entry skid buffer decouple the
//   sides; in_ready drops only while the skid entry is occupied.
//   Reset (rst_n low, synchronous): configuration cleared to zero, sequence
//   idle with no shots remaining, shutter low, output channel empty.
// ----------------------------------------------------------------------------
module stepped_shot_sequencer_core (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  // requests
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_kind,
  input  logic                in_motor_idle,
  // results
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_shutter_on,
  output logic                out_move_request,
  output logic signed [15:0]  out_move_steps,
  output logic                out_home_request,
  output logic                out_zero_position,
  output logic [15:0]         out_shots_left
);

  ssq_pkg::cfg_t       cfg_r;
  ssq_pkg::seq_state_t state_r;
  ssq_pkg::seq_state_t state_nxt;
  ssq_pkg::result_t    step_res;
  ssq_pkg::result_t    out_data_r;
  ssq_pkg::result_t    skid_data_r;
  logic                out_valid_r;
  logic                skid_valid_r;
  logic                in_fire;
  logic                out_fire;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (ssq_pkg::cfg_reg_t'(cfg_index))
        ssq_pkg::REG_SHOT_TOTAL:  cfg_r.shot_total         <= cfg_wdata;
        ssq_pkg::REG_MOVE_DIST:   cfg_r.move_distance      <= cfg_wdata;
        ssq_pkg::REG_START_DELAY: cfg_r.start_delay        <= cfg_wdata;
        ssq_pkg::REG_SETTLE_TIME: cfg_r.settle_time        <= cfg_wdata;
        ssq_pkg::REG_HOLD_TIME:   cfg_r.hold_time          <= cfg_wdata;
        ssq_pkg::REG_RETURN_HOME: cfg_r.return_home_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  ssq_step u_step (
    .cfg        (cfg_r),
    .cur        (state_r),
    .kind       (in_kind),
    .motor_idle (in_motor_idle),
    .nxt        (state_nxt),
    .res        (step_res)
  );

  // Advance the sequencer state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{first_shot_pending: 1'b1, default: '0};
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Output register and skid entry: valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_ready && in_fire) begin
        skid_valid_r <= 1'b1;
      end else if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
      if (in_fire || skid_valid_r) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output register and skid entry: payload
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_data_r <= skid_valid_r ? skid_data_r : step_res;
    end
    if (in_fire && out_valid_r && !out_ready) begin
      skid_data_r <= step_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_shutter_on    = out_data_r.shutter_on;
  assign out_move_request  = out_data_r.move_request;
  assign out_move_steps    = out_data_r.move_steps;
  assign out_home_request  = out_data_r.home_request;
  assign out_zero_position = out_data_r.zero_position;
  assign out_shots_left    = out_data_r.shots_left;

  // Checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_move_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_move_request) |-> (!out_home_request && !out_zero_position))
    else $error("move request combined with home or zero");

  a_steps_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_move_request) |-> (out_move_steps == '0))
    else $error("move steps set without a move request");

  a_arm_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_kind) |=> (state_r.first_shot_pending && state_r.hold_left == '0))
    else $error("arm did not restart the sequence");

endmodule
